>>> rtl/bstfq_pkg.sv
// ---------------------------------------------------------------------------
// bstfq_pkg
// shared types and constants for the battery self-test fault qualifier
// ---------------------------------------------------------------------------
`default_nettype none

package bstfq_pkg;

   // work modes carried in the request tuser field
   typedef enum logic [1:0] {
      WORK_DISCHARGE = 2'd0,
      WORK_CHARGE    = 2'd1
   } mode_type;

   // register indexes, byte address is four times the index
   typedef enum logic [1:0] {
      REG_SERIES_COUNT    = 2'd0,
      REG_INSUL_LIMIT     = 2'd1,
      REG_CURRENT_LIMIT   = 2'd2,
      REG_CELL_HIGH_LIMIT = 2'd3
   } reg_index_type;

   localparam int CNT_W       = 2;
   localparam int NUM_DIS     = 6;
   localparam int NUM_CHG     = 5;
   localparam int NUM_FLAGS   = 7;
   localparam int PACK_TH_W   = 24;

   // per-cell pack thresholds, multiplied by the series count
   localparam logic [PACK_TH_W-1:0] PACK_DIS_WARM = 24'd2850;
   localparam logic [PACK_TH_W-1:0] PACK_DIS_COLD = 24'd2700;
   localparam logic [PACK_TH_W-1:0] PACK_CHG_HIGH = 24'd37000;

   // discharge cell undervoltage thresholds
   localparam logic [15:0] CELL_DIS_WARM = 16'd2800;
   localparam logic [15:0] CELL_DIS_COLD = 16'd2500;

   // temperatures, degrees C plus 40
   localparam logic [7:0] TEMP_WARM_MIN = 8'd40;   // 0 C
   localparam logic [7:0] DIS_TEMP_HIGH = 8'd100;  // 60 C
   localparam logic [7:0] DIS_TEMP_LOW  = 8'd10;   // -30 C
   localparam logic [7:0] CHG_TEMP_HIGH = 8'd95;   // 55 C
   localparam logic [7:0] CHG_TEMP_LOW  = 8'd35;   // -5 C

   // register reset values
   localparam logic [7:0]  RST_SERIES_COUNT    = 8'd96;
   localparam logic [7:0]  RST_INSUL_LIMIT     = 8'd36;
   localparam logic [15:0] RST_CURRENT_LIMIT   = 16'd650;
   localparam logic [15:0] RST_CELL_HIGH_LIMIT = 16'd37000;

   // pass bits of one measurement set
   typedef struct packed {
      logic               update;
      mode_type           mode;
      logic [NUM_DIS-1:0] dis_pass;
      logic [NUM_CHG-1:0] chg_pass;
      logic               open_wire;
   } check_type;

   // qualified codes of one measurement set
   typedef struct packed {
      logic [NUM_FLAGS-1:0] fault_flags;
      logic [NUM_FLAGS-1:0] pending_flags;
   } qual_type;

endpackage

`default_nettype wire

>>> rtl/bstfq_qualify.sv
// ---------------------------------------------------------------------------
// bstfq_qualify
// per-check fail counters and fault / pending code generation
// ---------------------------------------------------------------------------
`default_nettype none

module bstfq_qualify #(
   parameter int CONFIRM_COUNT = 3
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire bstfq_pkg::check_type  check,
   output bstfq_pkg::qual_type        qual
);
   import bstfq_pkg::*;

   localparam int NUM_CNT = NUM_DIS + NUM_CHG;
   localparam logic [CNT_W-1:0] CONFIRM = CNT_W'(CONFIRM_COUNT);

   logic [CNT_W-1:0]   fail_count_ff [NUM_CNT];
   logic [CNT_W-1:0]   fail_count_in [NUM_CNT];
   logic [NUM_CNT-1:0] pass_all;
   logic [NUM_CNT-1:0] active;
   logic [NUM_CNT-1:0] fault_all;
   logic [NUM_CNT-1:0] pend_all;

   assign pass_all = {check.chg_pass, check.dis_pass};
   assign active   = {{NUM_CHG{check.mode == WORK_CHARGE}},
                      {NUM_DIS{check.mode == WORK_DISCHARGE}}};

   always_comb begin
      logic [CNT_W-1:0] inc;
      for (int i = 0; i < NUM_CNT; i++) begin
         inc = (fail_count_ff[i] < CONFIRM) ? fail_count_ff[i] + 1'b1 : fail_count_ff[i];
         fault_all[i] = !pass_all[i] && (inc >= CONFIRM);
         pend_all[i]  = !pass_all[i] && (inc < CONFIRM);
         if (check.update && active[i]) begin
            fail_count_in[i] = pass_all[i] ? '0 : inc;
         end else begin
            fail_count_in[i] = fail_count_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CNT; i++) fail_count_ff[i] <= '0;
      end else begin
         for (int i = 0; i < NUM_CNT; i++) fail_count_ff[i] <= fail_count_in[i];
      end
   end

   // flag placement follows evaluation order, open wire after the counted checks
   always_comb begin
      qual = '0;
      case (check.mode)
         WORK_DISCHARGE: begin
            qual.fault_flags   = {check.open_wire, fault_all[NUM_DIS-1:0]};
            qual.pending_flags = {1'b0, pend_all[NUM_DIS-1:0]};
         end
         WORK_CHARGE: begin
            qual.fault_flags   = {1'b0, check.open_wire, fault_all[NUM_CNT-1:NUM_DIS]};
            qual.pending_flags = {2'b00, pend_all[NUM_CNT-1:NUM_DIS]};
         end
         default: qual = '0;
      endcase
   end

endmodule

`default_nettype wire

>>> rtl/battery_self_test_fault_qualifier.sv
// ---------------------------------------------------------------------------
// battery_self_test_fault_qualifier
// qualifies battery threshold checks with per-check fail counters
// ---------------------------------------------------------------------------
//
//  channel  | direction | payload
//  ---------+-----------+---------------------------------------------------
//  req_     | in        | one measurement set, work mode in tuser
//  rsp_     | out       | one self-test result per request
//  csr_     | in/out    | four limit registers, apb-style, no wait states
//
//  a request is registered on acceptance, checked and qualified from the
//  input register and written to the result register once that is free;
//  one request per cycle sustained unless rsp_ stalls. the counter update
//  sits in that single step so consecutive requests see each other's counters
//  reset clears the fail counters and loads the register defaults
//  a stalled rsp_ side holds the result; one more request may wait in the
//  input register before req_tready drops
//
`default_nettype none

module battery_self_test_fault_qualifier #(
   parameter int CONFIRM_COUNT = 3
) (
   input  wire logic         clock,
   input  wire logic         reset,

   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // total_voltage[23:0], min_cell_voltage[39:24], max_cell_voltage[55:40],
   // avg_temp[63:56], max_temp[71:64], min_temp[79:72], pack_current[95:80],
   // insulation_value[103:96], open_wire_status[111:104], init_status[119:112]
   input  wire logic [119:0] req_tdata,
   // work_mode[1:0]
   input  wire logic [1:0]   req_tuser,

   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // self_test_fail[0], combined_code[2:1], fault_flags[9:3],
   // pending_flags[16:10], zero fill[23:17]
   output logic [23:0]       rsp_tdata,

   // configuration port
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import bstfq_pkg::*;

   // ------------------------------------------------------------------
   // configuration registers
   // ------------------------------------------------------------------
   logic [7:0]            series_count_ff,    series_count_in;
   logic [7:0]            insul_limit_ff,     insul_limit_in;
   logic signed [15:0]    current_limit_ff,   current_limit_in;
   logic [15:0]           cell_high_limit_ff, cell_high_limit_in;
   // pack thresholds scaled by the series count when it is written
   logic [PACK_TH_W-1:0]  pack_warm_th_ff,    pack_warm_th_in;
   logic [PACK_TH_W-1:0]  pack_cold_th_ff,    pack_cold_th_in;
   logic [PACK_TH_W-1:0]  pack_chg_th_ff,     pack_chg_th_in;

   logic                  csr_write;
   reg_index_type         csr_index;
   logic [PACK_TH_W-1:0]  series_wide;

   assign csr_pready  = 1'b1;
   assign csr_write   = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index   = reg_index_type'(csr_paddr[3:2]);
   assign series_wide = {16'd0, csr_pwdata[7:0]};

   always_comb begin
      series_count_in    = series_count_ff;
      insul_limit_in     = insul_limit_ff;
      current_limit_in   = current_limit_ff;
      cell_high_limit_in = cell_high_limit_ff;
      pack_warm_th_in    = pack_warm_th_ff;
      pack_cold_th_in    = pack_cold_th_ff;
      pack_chg_th_in     = pack_chg_th_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_SERIES_COUNT: begin
               series_count_in = csr_pwdata[7:0];
               pack_warm_th_in = series_wide * PACK_DIS_WARM;
               pack_cold_th_in = series_wide * PACK_DIS_COLD;
               pack_chg_th_in  = series_wide * PACK_CHG_HIGH;
            end
            REG_INSUL_LIMIT:     insul_limit_in     = csr_pwdata[7:0];
            REG_CURRENT_LIMIT:   current_limit_in   = csr_pwdata[15:0];
            REG_CELL_HIGH_LIMIT: cell_high_limit_in = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         series_count_ff    <= RST_SERIES_COUNT;
         insul_limit_ff     <= RST_INSUL_LIMIT;
         current_limit_ff   <= RST_CURRENT_LIMIT;
         cell_high_limit_ff <= RST_CELL_HIGH_LIMIT;
         pack_warm_th_ff    <= PACK_TH_W'(PACK_DIS_WARM * {16'd0, RST_SERIES_COUNT});
         pack_cold_th_ff    <= PACK_TH_W'(PACK_DIS_COLD * {16'd0, RST_SERIES_COUNT});
         pack_chg_th_ff     <= PACK_TH_W'(PACK_CHG_HIGH * {16'd0, RST_SERIES_COUNT});
      end else begin
         series_count_ff    <= series_count_in;
         insul_limit_ff     <= insul_limit_in;
         current_limit_ff   <= current_limit_in;
         cell_high_limit_ff <= cell_high_limit_in;
         pack_warm_th_ff    <= pack_warm_th_in;
         pack_cold_th_ff    <= pack_cold_th_in;
         pack_chg_th_ff     <= pack_chg_th_in;
      end
   end

   // register read-back, signed limit is sign extended
   always_comb begin
      unique case (csr_index)
         REG_SERIES_COUNT:    csr_prdata = {24'd0, series_count_ff};
         REG_INSUL_LIMIT:     csr_prdata = {24'd0, insul_limit_ff};
         REG_CURRENT_LIMIT:   csr_prdata = {{16{current_limit_ff[15]}}, current_limit_ff};
         REG_CELL_HIGH_LIMIT: csr_prdata = {16'd0, cell_high_limit_ff};
         default:             csr_prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // input register
   // ------------------------------------------------------------------
   logic          in_valid_ff, in_valid_in;
   logic [119:0]  in_data_ff,  in_data_in;
   mode_type      in_mode_ff,  in_mode_in;
   logic          advance;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [23:0]   rsp_data_ff,  rsp_data_in;

   // the result register frees up whenever it is empty or being taken
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_data_in  = in_data_ff;
      in_mode_in  = in_mode_ff;
      if (req_tready) begin
         in_valid_in = req_tvalid;
         in_data_in  = req_tdata;
         in_mode_in  = mode_type'(req_tuser);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_data_ff <= in_data_in;
      in_mode_ff <= in_mode_in;
   end

   // ------------------------------------------------------------------
   // threshold checks
   // ------------------------------------------------------------------
   logic [23:0]        total_voltage;
   logic [15:0]        min_cell_voltage;
   logic [15:0]        max_cell_voltage;
   logic [7:0]         avg_temp;
   logic [7:0]         max_temp;
   logic [7:0]         min_temp;
   logic signed [15:0] pack_current;
   logic [7:0]         insulation_value;
   logic [7:0]         open_wire_status;
   logic [7:0]         init_status;
   logic               warm;
   logic               insul_ok;
   check_type          check;
   qual_type           qual;
   logic [1:0]         combined_code;
   logic               self_test_fail;

   assign total_voltage    = in_data_ff[23:0];
   assign min_cell_voltage = in_data_ff[39:24];
   assign max_cell_voltage = in_data_ff[55:40];
   assign avg_temp         = in_data_ff[63:56];
   assign max_temp         = in_data_ff[71:64];
   assign min_temp         = in_data_ff[79:72];
   assign pack_current     = in_data_ff[95:80];
   assign insulation_value = in_data_ff[103:96];
   assign open_wire_status = in_data_ff[111:104];
   assign init_status      = in_data_ff[119:112];

   // thresholds at or above 0 C use the warm set
   assign warm     = avg_temp >= TEMP_WARM_MIN;
   assign insul_ok = insulation_value < insul_limit_ff;

   always_comb begin
      check.update    = advance;
      check.mode      = in_mode_ff;
      check.open_wire = open_wire_status != 8'd0;
      // discharge: pack uv, cell uv, over temp, under temp, current, insulation
      check.dis_pass[0] = total_voltage > (warm ? pack_warm_th_ff : pack_cold_th_ff);
      check.dis_pass[1] = min_cell_voltage > (warm ? CELL_DIS_WARM : CELL_DIS_COLD);
      check.dis_pass[2] = max_temp < DIS_TEMP_HIGH;
      check.dis_pass[3] = min_temp > DIS_TEMP_LOW;
      check.dis_pass[4] = pack_current > current_limit_ff;
      check.dis_pass[5] = insul_ok;
      // charge: pack ov, cell ov, over temp, under temp, insulation
      check.chg_pass[0] = total_voltage < pack_chg_th_ff;
      check.chg_pass[1] = max_cell_voltage < cell_high_limit_ff;
      check.chg_pass[2] = max_temp < CHG_TEMP_HIGH;
      check.chg_pass[3] = min_temp > CHG_TEMP_LOW;
      check.chg_pass[4] = insul_ok;
   end

   bstfq_qualify #(
      .CONFIRM_COUNT (CONFIRM_COUNT)
   ) u_qualify (
      .clock (clock),
      .reset (reset),
      .check (check),
      .qual  (qual)
   );

   // bit 0 any confirmed fault, bit 1 any pending
   assign combined_code = {|qual.pending_flags, |qual.fault_flags};

   // unknown modes always fail and report no codes
   always_comb begin
      case (in_mode_ff) inside
         WORK_DISCHARGE, WORK_CHARGE:
            self_test_fail = (combined_code != 2'd0) || (init_status != 8'd0);
         default:
            self_test_fail = 1'b1;
      endcase
   end

   // ------------------------------------------------------------------
   // result register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {7'd0, qual.pending_flags, qual.fault_flags,
                         combined_code, self_test_fail};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

>>> tb/battery_self_test_checker.sv
// ---------------------------------------------------------------------------
// battery_self_test_checker
// watches the request, response and register channels of the self-test
// fault qualifier, predicts each verdict and compares it with the response
// ---------------------------------------------------------------------------
`default_nettype none

module battery_self_test_checker #(
   parameter int CONFIRM_COUNT = 3
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [119:0] req_tdata,
   input  wire logic [1:0]   req_tuser,
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [23:0]  rsp_tdata,
   input  wire logic         csr_psel,
   input  wire logic         csr_penable,
   input  wire logic         csr_pwrite,
   input  wire logic [3:0]   csr_paddr,
   input  wire logic [31:0]  csr_pwdata,
   input  wire logic         csr_pready,
   output int                mismatches,
   output int                verdicts_owed
);
   import bstfq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CODE_PASS    = 2'd0;
   localparam logic [1:0] CODE_FAULT   = 2'd1;
   localparam logic [1:0] CODE_PENDING = 2'd2;
   localparam int NUM_RUNS = 11;

   // one verdict, msb to lsb as on rsp_tdata[16:0]
   typedef struct packed {
      logic [6:0] pending_flags;
      logic [6:0] fault_flags;
      logic [1:0] combined_code;
      logic       self_test_fail;
   } verdict_type;

   logic [7:0]         series_count    = 8'd96;
   logic [7:0]         insul_limit     = 8'd36;
   logic signed [15:0] current_limit   = 16'sd650;
   logic [15:0]        cell_high_limit = 16'd37000;
   logic [1:0]         fail_run [NUM_RUNS];
   verdict_type        verdict_q [$];
   int                 errors = 0;

   assign mismatches = errors;

   function automatic logic [1:0] qualify_check(int idx, logic ok);
      if (ok) begin
         fail_run[idx] = '0;
         return CODE_PASS;
      end
      if (fail_run[idx] < CONFIRM_COUNT) fail_run[idx] = fail_run[idx] + 2'd1;
      return (fail_run[idx] >= CONFIRM_COUNT) ? CODE_FAULT : CODE_PENDING;
   endfunction

   function automatic verdict_type qualify_measurements(logic [119:0] d, logic [1:0] mode);
      logic [23:0]        tv;
      logic [15:0]        vmin, vmax;
      logic [7:0]         tavg, tmax, tmin, insul, ow, init;
      logic signed [15:0] cur;
      logic [1:0]         code [7];
      int unsigned        pack_th;
      int unsigned        cell_th;
      int                 n;
      verdict_type        v;
      tv    = d[23:0];
      vmin  = d[39:24];
      vmax  = d[55:40];
      tavg  = d[63:56];
      tmax  = d[71:64];
      tmin  = d[79:72];
      cur   = d[95:80];
      insul = d[103:96];
      ow    = d[111:104];
      init  = d[119:112];
      v = '0;
      n = 0;
      if (mode == WORK_DISCHARGE) begin
         // warm pack (avg at or above 0 C) uses the higher thresholds
         pack_th = (tavg >= 8'd40 ? 2850 : 2700) * series_count;
         cell_th = (tavg >= 8'd40) ? 2800 : 2500;
         code[0] = qualify_check(0, tv > pack_th);
         code[1] = qualify_check(1, vmin > cell_th);
         code[2] = qualify_check(2, tmax < 8'd100);
         code[3] = qualify_check(3, tmin > 8'd10);
         code[4] = qualify_check(4, cur > current_limit);
         code[5] = qualify_check(5, insul < insul_limit);
         code[6] = (ow != 0) ? CODE_FAULT : CODE_PASS;
         n = 7;
      end else if (mode == WORK_CHARGE) begin
         pack_th = 37000 * series_count;
         code[0] = qualify_check(6, tv < pack_th);
         code[1] = qualify_check(7, vmax < cell_high_limit);
         code[2] = qualify_check(8, tmax < 8'd95);
         code[3] = qualify_check(9, tmin > 8'd35);
         code[4] = qualify_check(10, insul < insul_limit);
         code[5] = (ow != 0) ? CODE_FAULT : CODE_PASS;
         n = 6;
      end
      for (int i = 0; i < n; i++) begin
         v.combined_code |= code[i];
         if (code[i] == CODE_FAULT) v.fault_flags[i] = 1'b1;
         if (code[i] == CODE_PENDING) v.pending_flags[i] = 1'b1;
      end
      if (mode != WORK_DISCHARGE && mode != WORK_CHARGE) v.self_test_fail = 1'b1;
      else v.self_test_fail = (v.combined_code != 0) || (init != 0);
      return v;
   endfunction

   task automatic compare_field(string field, int want, int got);
      if (want != got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      verdict_type want;
      verdict_type got;
      if (reset) begin
         series_count    = 8'd96;
         insul_limit     = 8'd36;
         current_limit   = 16'sd650;
         cell_high_limit = 16'd37000;
         foreach (fail_run[i]) fail_run[i] = '0;
         verdict_q.delete();
         verdicts_owed <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               REG_SERIES_COUNT:    series_count    = csr_pwdata[7:0];
               REG_INSUL_LIMIT:     insul_limit     = csr_pwdata[7:0];
               REG_CURRENT_LIMIT:   current_limit   = csr_pwdata[15:0];
               REG_CELL_HIGH_LIMIT: cell_high_limit = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[16:0];
            if (verdict_q.size() == 0) begin
               errors++;
               $display("%0t: response with no request waiting, expected none, actual %h",
                        $time, rsp_tdata);
            end else begin
               want = verdict_q.pop_front();
               compare_field("self_test_fail", want.self_test_fail, got.self_test_fail);
               compare_field("combined_code", want.combined_code, got.combined_code);
               compare_field("fault_flags", want.fault_flags, got.fault_flags);
               compare_field("pending_flags", want.pending_flags, got.pending_flags);
               compare_field("zero fill", 0, rsp_tdata[23:17]);
            end
         end
         if (req_tvalid && req_tready)
            verdict_q.push_back(qualify_measurements(req_tdata, req_tuser));
         verdicts_owed <= verdict_q.size();
      end
   end

endmodule

`default_nettype wire

>>> tb/tb_battery_self_test_fault_qualifier.sv
// ---------------------------------------------------------------------------
// tb_battery_self_test_fault_qualifier
// drives measurement sets and limit register writes into the self-test
// fault qualifier; a separate checker predicts and compares every verdict
// ---------------------------------------------------------------------------
`default_nettype none

module tb_battery_self_test_fault_qualifier;
   import bstfq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CONFIRM     = 3;
   localparam int SEGMENTS    = 6;
   localparam int SEG_ITEMS   = 80;
   localparam int SETTLE      = 20;
   localparam int CYCLE_LIMIT = 200000;

   // work mode with no checks, not named in the package
   localparam logic [1:0] MODE_OTHER = 2'd2;

   // one measurement set as the stimulus sees it
   typedef struct {
      logic [1:0]  mode;
      logic [23:0] tv;
      logic [15:0] vmin;
      logic [15:0] vmax;
      logic [7:0]  tavg;
      logic [7:0]  tmax;
      logic [7:0]  tmin;
      logic [15:0] cur;
      logic [7:0]  insul;
      logic [7:0]  ow;
      logic [7:0]  init;
   } meas_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   // total_voltage[23:0], min_cell_voltage[39:24], max_cell_voltage[55:40],
   // avg_temp[63:56], max_temp[71:64], min_temp[79:72], pack_current[95:80],
   // insulation_value[103:96], open_wire_status[111:104], init_status[119:112]
   logic [119:0] req_tdata   = '0;
   // work_mode[1:0]
   logic [1:0]   req_tuser   = '0;
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   // self_test_fail[0], combined_code[2:1], fault_flags[9:3],
   // pending_flags[16:10], zero fill[23:17]
   logic [23:0]  rsp_tdata;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [3:0]   csr_paddr   = '0;
   logic [31:0]  csr_pwdata  = '0;
   logic [31:0]  csr_prdata;
   logic         csr_pready;

   int mismatches;
   int verdicts_owed;
   int cycles        = 0;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;

   // limits as last written, used to aim stimulus at the thresholds
   int cfg_series = RST_SERIES_COUNT;
   int cfg_insul  = RST_INSUL_LIMIT;
   int cfg_cur    = 650;
   int cfg_cell   = RST_CELL_HIGH_LIMIT;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   battery_self_test_fault_qualifier #(
      .CONFIRM_COUNT(CONFIRM)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   battery_self_test_checker #(
      .CONFIRM_COUNT(CONFIRM)
   ) u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .mismatches   (mismatches),
      .verdicts_owed(verdicts_owed)
   );

   // receiver back-pressure, rate set per phase
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);

   // watchdog against a hung handshake
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("[battery_self_test_fault_qualifier] ERROR");
         $finish;
      end
   end

   // value within two of a threshold, clipped to the field range
   function automatic int unsigned near_value(int unsigned center, int unsigned maxv);
      int unsigned lo;
      int unsigned hi;
      lo = (center > 2) ? center - 2 : 0;
      hi = (center + 2 > maxv) ? maxv : center + 2;
      if (lo > maxv) lo = maxv;
      return $urandom_range(hi, lo);
   endfunction

   function automatic logic [15:0] near_current(int c);
      int lo;
      int hi;
      lo = (c - 2 < -32768) ? -32768 : c - 2;
      hi = (c + 2 > 32767) ? 32767 : c + 2;
      return 16'($urandom_range(hi - lo) + lo);
   endfunction

   // a set that passes every check of both modes that the current limits let pass,
   // then each field is pushed to a threshold or made random at stress_pct
   function automatic meas_type make_set(logic [1:0] mode, int stress_pct);
      meas_type s;
      s.mode  = mode;
      s.tv    = 24'(3300 * cfg_series + $urandom_range(200));
      s.vmin  = 16'($urandom_range(3600, 2900));
      s.vmax  = (cfg_cell == 0) ? 16'd0 : 16'($urandom_range(cfg_cell - 1, 0));
      s.tavg  = 8'($urandom_range(70, 20));
      s.tmax  = 8'($urandom_range(90, 50));
      s.tmin  = 8'($urandom_range(80, 40));
      s.cur   = (cfg_cur >= 32767) ? 16'h7fff
                : 16'(cfg_cur + 1 + int'($urandom_range(32766 - cfg_cur)));
      s.insul = (cfg_insul == 0) ? 8'd0 : 8'($urandom_range(cfg_insul - 1, 0));
      s.ow    = '0;
      s.init  = '0;
      if ($urandom_range(99) < stress_pct) begin
         if ($urandom_range(1)) begin
            case ($urandom_range(2))
               0: s.tv = 24'(near_value(2850 * cfg_series, 24'hffffff));
               1: s.tv = 24'(near_value(2700 * cfg_series, 24'hffffff));
               default: s.tv = 24'(near_value(37000 * cfg_series, 24'hffffff));
            endcase
         end else s.tv = 24'($urandom());
      end
      if ($urandom_range(99) < stress_pct)
         s.vmin = $urandom_range(1) ? 16'(near_value($urandom_range(1) ? 2800 : 2500, 65535))
                                    : 16'($urandom());
      if ($urandom_range(99) < stress_pct)
         s.vmax = $urandom_range(1) ? 16'(near_value(cfg_cell, 65535)) : 16'($urandom());
      if ($urandom_range(99) < stress_pct)
         s.tavg = $urandom_range(1) ? 8'(near_value(40, 255)) : 8'($urandom());
      if ($urandom_range(99) < stress_pct)
         s.tmax = $urandom_range(1) ? 8'(near_value($urandom_range(1) ? 100 : 95, 255))
                                    : 8'($urandom());
      if ($urandom_range(99) < stress_pct)
         s.tmin = $urandom_range(1) ? 8'(near_value($urandom_range(1) ? 10 : 35, 255))
                                    : 8'($urandom());
      if ($urandom_range(99) < stress_pct)
         s.cur = $urandom_range(1) ? near_current(cfg_cur) : 16'($urandom());
      if ($urandom_range(99) < stress_pct)
         s.insul = $urandom_range(1) ? 8'(near_value(cfg_insul, 255)) : 8'($urandom());
      // open wire and init failures are kept rarer so that passes still show up
      if ($urandom_range(199) < stress_pct) s.ow = 8'($urandom());
      if ($urandom_range(199) < stress_pct) s.init = 8'($urandom());
      return s;
   endfunction

   // one request; valid stays high into the next request when there is no gap
   task automatic send_set(meas_type s);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.mode;
      req_tdata  <= {s.init, s.ow, s.insul, s.cur, s.tmin, s.tmax, s.tavg,
                     s.vmax, s.vmin, s.tv};
      do @(posedge clock); while (!req_tready);
   endtask

   // stop sending and wait until every verdict has come back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (verdicts_owed != 0) @(posedge clock);
   endtask

   // apb write: setup cycle, then access cycle, register taken at its end
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_limits(int series, int insul, int cur, int cell_mv);
      csr_write(REG_SERIES_COUNT, 32'(series));
      csr_write(REG_INSUL_LIMIT, 32'(insul));
      csr_write(REG_CURRENT_LIMIT, {16'h0, 16'(cur)});
      csr_write(REG_CELL_HIGH_LIMIT, 32'(cell_mv));
      cfg_series = series;
      cfg_insul  = insul;
      cfg_cur    = cur;
      cfg_cell   = cell_mv;
   endtask

   initial begin
      meas_type   s;
      meas_type   worst;
      logic [1:0] m;
      int         k;
      int         burst;
      int         stress;
      int         r;

      // first phase: sender gaps 32 percent, receiver stalls 63 percent
      send_idle_pct = 32;
      rsp_stall_pct = 63;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // ---- directed, at the register reset values ----
      send_set(make_set(WORK_DISCHARGE, 0));

      // every discharge check failing: pending, pending, then fault;
      // an other-mode request in between must leave the counters alone
      worst = make_set(WORK_DISCHARGE, 0);
      worst.tv = '0; worst.vmin = '0; worst.tmax = 8'hff; worst.tmin = '0;
      worst.cur = 16'h8000; worst.insul = 8'hff; worst.ow = 8'hff; worst.init = 8'hff;
      send_set(worst);
      send_set(worst);
      s = make_set(MODE_OTHER, 0);
      s.tv = 24'($urandom()); s.cur = 16'($urandom()); s.ow = 8'($urandom());
      send_set(s);
      send_set(worst);

      // all fields at their maximum but open wire and init status, which are zero
      s = '{WORK_DISCHARGE, 24'hffffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff,
            16'h7fff, 8'hff, 8'h00, 8'h00};
      send_set(s);

      // warm thresholds hit exactly: every counted check fails
      s = make_set(WORK_DISCHARGE, 0);
      s.tavg = 8'd40; s.tv = 24'(2850 * 96); s.vmin = 16'd2800; s.tmax = 8'd100;
      s.tmin = 8'd10; s.cur = 16'd650; s.insul = 8'd36;
      send_set(s);
      // just past every cold threshold: all pass, counters clear
      s.tavg = 8'd39; s.tv = 24'(2700 * 96 + 1); s.vmin = 16'd2501; s.tmax = 8'd99;
      s.tmin = 8'd11; s.cur = 16'd651; s.insul = 8'd35;
      send_set(s);
      // cold thresholds hit exactly
      s.tv = 24'(2700 * 96); s.vmin = 16'd2500;
      send_set(s);
      // just past the warm thresholds
      s.tavg = 8'd40; s.tv = 24'(2850 * 96 + 1); s.vmin = 16'd2801;
      send_set(s);
      // healthy but not initialised
      s = make_set(WORK_DISCHARGE, 0);
      s.init = 8'd1;
      send_set(s);

      // every charge check failing three times
      worst = make_set(WORK_CHARGE, 0);
      worst.tv = 24'hffffff; worst.vmax = 16'hffff; worst.tmax = 8'hff; worst.tmin = '0;
      worst.insul = 8'hff; worst.ow = 8'd1;
      repeat (3) send_set(worst);

      // charge thresholds hit exactly, then just inside
      s = make_set(WORK_CHARGE, 0);
      s.tv = 24'(37000 * 96); s.vmax = 16'd37000; s.tmax = 8'd95; s.tmin = 8'd35;
      s.insul = 8'd36;
      send_set(s);
      s.tv = 24'(37000 * 96 - 1); s.vmax = 16'd36999; s.tmax = 8'd94; s.tmin = 8'd36;
      s.insul = 8'd35;
      send_set(s);

      // all-zero fields in both modes, all-ones in the other mode
      s = '{WORK_CHARGE, '0, '0, '0, '0, '0, '0, '0, '0, '0, '0};
      send_set(s);
      s.mode = WORK_DISCHARGE;
      send_set(s);
      s = '{MODE_OTHER, 24'hffffff, 16'hffff, 16'hffff, 8'hff, 8'hff, 8'hff,
            16'hffff, 8'hff, 8'hff, 8'hff};
      send_set(s);

      // hold off until the pipeline is empty before touching the registers
      wait_for_results();

      // zero series cells: the charge pack check fails whatever the voltage, the discharge one fails only at zero
      set_limits(0, RST_INSUL_LIMIT, 650, RST_CELL_HIGH_LIMIT);
      send_set(make_set(WORK_DISCHARGE, 0));
      send_set(make_set(WORK_CHARGE, 0));
      send_set(make_set(WORK_DISCHARGE, 0));

      // ---- random, in bursts of one mode so fail runs build up ----
      for (int seg = 0; seg < SEGMENTS; seg++) begin
         wait_for_results();
         case (seg)
            0: set_limits(255, 255, -32768, 65535);
            1: set_limits(1, 0, 32767, 0);
            default: set_limits($urandom_range(255, 1), $urandom_range(255),
                                int'($urandom_range(65535)) - 32768, $urandom_range(65535));
         endcase
         // idle pattern: swapped in the middle phase, none in the last one
         if (seg < 2) begin
            send_idle_pct = 32;
            rsp_stall_pct = 63;
         end else if (seg < 4) begin
            send_idle_pct = 63;
            rsp_stall_pct = 32;
         end else begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         k = 0;
         while (k < SEG_ITEMS) begin
            burst = $urandom_range(8, 1);
            r = $urandom_range(99);
            m = (r < 45) ? WORK_DISCHARGE : (r < 90) ? WORK_CHARGE : MODE_OTHER;
            r = $urandom_range(2);
            stress = (r == 0) ? 3 : (r == 1) ? 25 : 60;
            repeat (burst) begin
               send_set(make_set(m, stress));
               k++;
            end
         end
      end

      // drain, let any stray response show up, then give the verdict
      wait_for_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0) $display("[battery_self_test_fault_qualifier] OK");
      else $display("[battery_self_test_fault_qualifier] ERROR");
      $finish;
   end

endmodule

`default_nettype wire
